[rtl/rtha_pkg.sv]
// Shared types, widths and constants of the right-triangle solver.
package rtha_pkg;

  localparam int IN_W          = 16;
  localparam int HYP_W         = 17;
  localparam int ANG_W         = 15;
  localparam int CW            = 64;
  localparam int ZW            = 32;
  localparam int SQR_W         = 2 * IN_W;
  localparam int SUM_W         = SQR_W + 1;
  localparam int SQ_W          = SUM_W + 1;
  localparam int ROOT_W        = SQ_W / 2;
  localparam int REM_W         = ROOT_W + 1;
  localparam int SQRT_STEPS    = SQ_W / 2;
  localparam int CORDIC_STAGES = 31;
  localparam int FRONT_STAGES  = 3;
  localparam int PIPE_DEPTH    = FRONT_STAGES + CORDIC_STAGES + 1;
  localparam int SCALE_BITS    = 60;
  localparam int Q30_FRAC      = 30;
  localparam int RND_W         = ZW + 1;

  localparam logic [ZW-2:0] HALF_PI_Q30 = 31'd1686629713;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [SQ_W-1:0]      sq;
    logic [REM_W-1:0]     rem;
    logic [ROOT_W-1:0]    root;
    logic                 a_zero;
    logic                 b_zero;
  } cord_t;

  typedef struct packed {
    logic [HYP_W-1:0] hyp;
    logic [ANG_W-1:0] angle_a;
    logic [ANG_W-1:0] angle_b;
    logic             degen;
  } res_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:  v = 32'sh3243F6A8;
      1:  v = 32'sh1DAC6705;
      2:  v = 32'sh0FADBAFC;
      3:  v = 32'sh07F56EA6;
      4:  v = 32'sh03FEAB76;
      5:  v = 32'sh01FFD55B;
      6:  v = 32'sh00FFFAAA;
      7:  v = 32'sh007FFF55;
      8:  v = 32'sh003FFFEA;
      9:  v = 32'sh001FFFFD;
      10: v = 32'sh000FFFFF;
      11: v = 32'sh0007FFFF;
      12: v = 32'sh0003FFFF;
      13: v = 32'sh0001FFFF;
      14: v = 32'sh0000FFFF;
      15: v = 32'sh00007FFF;
      16: v = 32'sh00003FFF;
      17: v = 32'sh00001FFF;
      18: v = 32'sh00000FFF;
      19: v = 32'sh000007FF;
      20: v = 32'sh000003FF;
      21: v = 32'sh000001FF;
      22: v = 32'sh000000FF;
      23: v = 32'sh0000007F;
      24: v = 32'sh0000003F;
      25: v = 32'sh0000001F;
      26: v = 32'sh0000000F;
      27: v = 32'sh00000008;
      28: v = 32'sh00000004;
      29: v = 32'sh00000002;
      30: v = 32'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/right_triangle_hypotenuse_angles.sv]
// An accepted transaction passes the front, CORDIC and back stages toward the output register.
// Throughput: one transaction per cycle while in_stall is low; the 31 CORDIC stages and
// 17 root-digit steps each take one pipeline register; stages accept data while en is high.
// A stalled output fills a one-entry skid register, after which the whole pipeline holds.
// Reset (synchronous, active low) clears only the valid bits; data registers are not reset.
module right_triangle_hypotenuse_angles import rtha_pkg::*; #(
  parameter int SIDE_BITS       = 16,
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IN_W-1:0]  in_side_a,
  input  logic [IN_W-1:0]  in_side_b,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [HYP_W-1:0] out_hypotenuse,
  output logic [ANG_W-1:0] out_angle_a,
  output logic [ANG_W-1:0] out_angle_b,
  output logic             out_degenerate
);

  logic [PIPE_DEPTH-1:0] valid_r;
  logic                  en;
  logic                  out_ld;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  res_t                  res;
  res_t                  out_r;
  res_t                  skid_r;
  cord_t                 cs [CORDIC_STAGES+1];

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign out_ld   = !out_valid_r || !out_stall;

  rtha_front #(
    .SIDE_BITS(SIDE_BITS)
  ) u_front (
    .clk    (clk),
    .en     (en),
    .side_a (in_side_a),
    .side_b (in_side_b),
    .q      (cs[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    rtha_stage #(
      .IDX(g)
    ) u_stage (
      .clk (clk),
      .en  (en),
      .d   (cs[g]),
      .q   (cs[g+1])
    );
  end

  rtha_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk (clk),
    .en  (en),
    .d   (cs[CORDIC_STAGES]),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ld) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= valid_r[PIPE_DEPTH-1];
      end
    end else if (!skid_valid_r && valid_r[PIPE_DEPTH-1]) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_ld && !skid_valid_r) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hypotenuse = out_r.hyp;
  assign out_angle_a    = out_r.angle_a;
  assign out_angle_b    = out_r.angle_b;
  assign out_degenerate = out_r.degen;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_hypotenuse == '0 && out_angle_a == '0 && out_angle_b == '0)
    else $error("degenerate result with nonzero fields");

  a_hyp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> out_hypotenuse != '0)
    else $error("zero hypotenuse on a nondegenerate result");

  a_skid_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

endmodule

[rtl/rtha_front.sv]
// Front stages: leg masking, squaring, sum of squares and CORDIC start vector.
module rtha_front import rtha_pkg::*; #(
  parameter int SIDE_BITS = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IN_W-1:0] side_a,
  input  logic [IN_W-1:0] side_b,
  output cord_t           q
);

  localparam int MASK_BITS = (SIDE_BITS < IN_W) ? SIDE_BITS : IN_W;
  localparam logic [IN_W-1:0] IN_MASK = IN_W'((65'd1 << MASK_BITS) - 65'd1);
  localparam int XSH = SCALE_BITS - SIDE_BITS;

  logic [IN_W-1:0]  a0_r;
  logic [IN_W-1:0]  b0_r;
  logic [IN_W-1:0]  a1_r;
  logic [IN_W-1:0]  b1_r;
  logic [SQR_W-1:0] aa1_r;
  logic [SQR_W-1:0] bb1_r;
  logic [SUM_W-1:0] sum;
  cord_t            q_nxt;
  cord_t            q_r;

  always_comb begin
    sum          = SUM_W'(aa1_r) + SUM_W'(bb1_r);
    q_nxt.x      = CW'(b1_r) << XSH;
    q_nxt.y      = CW'(a1_r) << XSH;
    q_nxt.z      = '0;
    q_nxt.sq     = SQ_W'(sum);
    q_nxt.rem    = '0;
    q_nxt.root   = '0;
    q_nxt.a_zero = (a1_r == '0);
    q_nxt.b_zero = (b1_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= side_a & IN_MASK;
      b0_r  <= side_b & IN_MASK;
      a1_r  <= a0_r;
      b1_r  <= b0_r;
      aa1_r <= SQR_W'(a0_r) * SQR_W'(a0_r);
      bb1_r <= SQR_W'(b0_r) * SQR_W'(b0_r);
      q_r   <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/rtha_stage.sv]
// One CORDIC vectoring stage, with a square-root digit step in the stages below SQRT_STEPS.
module rtha_stage import rtha_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cord_t d,
  output cord_t q
);

  localparam logic signed [ZW-1:0] ATAN = atan_q30(IDX);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [REM_W+1:0]     remt;
  logic [REM_W+1:0]     trial;
  logic [REM_W+1:0]     diff;
  logic                 ge;
  cord_t                q_nxt;
  cord_t                q_r;

  always_comb begin
    xs    = d.x >>> IDX;
    ys    = d.y >>> IDX;
    remt  = {d.rem, d.sq[SQ_W-1 -: 2]};
    trial = (REM_W+2)'({d.root, 2'b01});
    diff  = remt - trial;
    ge    = (remt >= trial);
    q_nxt = d;
    if (!d.y[CW-1]) begin
      q_nxt.x = d.x + ys;
      q_nxt.y = d.y - xs;
      q_nxt.z = d.z + ATAN;
    end else begin
      q_nxt.x = d.x - ys;
      q_nxt.y = d.y + xs;
      q_nxt.z = d.z - ATAN;
    end
    if (IDX < SQRT_STEPS) begin
      q_nxt.sq   = d.sq << 2;
      q_nxt.rem  = ge ? REM_W'(diff) : REM_W'(remt);
      q_nxt.root = {d.root[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/rtha_back.sv]
// Back stage: angle clamping, special legs, root rounding and output scaling.
module rtha_back import rtha_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  logic  clk,
  input  logic  en,
  input  cord_t d,
  output res_t  res
);

  localparam int RSH = Q30_FRAC - ANGLE_FRAC_BITS;
  localparam logic [RND_W-1:0] RHALF = RND_W'((64'd1 << RSH) >> 1);

  logic [ZW-2:0]     zc;
  logic [ROOT_W-1:0] hyp_nxt;
  logic              degen_nxt;
  logic [ZW-2:0]     za_r;
  logic [ZW-2:0]     zb_r;
  logic [ROOT_W-1:0] hyp_r;
  logic              degen_r;
  logic [RND_W-1:0]  sa;
  logic [RND_W-1:0]  sb;

  always_comb begin
    degen_nxt = d.a_zero && d.b_zero;
    priority if (d.a_zero) begin
      zc = '0;
    end else if (d.b_zero) begin
      zc = HALF_PI_Q30;
    end else if (d.z < 0) begin
      zc = '0;
    end else if ((ZW-1)'(d.z) > HALF_PI_Q30) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = (ZW-1)'(d.z);
    end
    hyp_nxt = (d.rem > REM_W'(d.root)) ? d.root + ROOT_W'(1) : d.root;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za_r    <= degen_nxt ? '0 : zc;
      zb_r    <= degen_nxt ? '0 : HALF_PI_Q30 - zc;
      hyp_r   <= hyp_nxt;
      degen_r <= degen_nxt;
    end
  end

  always_comb begin
    sa          = RND_W'(za_r) + RHALF;
    sb          = RND_W'(zb_r) + RHALF;
    res.hyp     = HYP_W'(hyp_r);
    res.angle_a = ANG_W'(sa >> RSH);
    res.angle_b = ANG_W'(sb >> RSH);
    res.degen   = degen_r;
  end

endmodule

[dv/right_triangle_hypotenuse_angles_test.sv]
// Self-checking testbench for the right-triangle hypotenuse and angle solver.
module right_triangle_hypotenuse_angles_test import rtha_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1400;
  localparam int SIDE_SCALE   = SCALE_BITS - IN_W;
  localparam int ANGLE_SHIFT  = Q30_FRAC - 14;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic [IN_W-1:0]  side_a;
    logic [IN_W-1:0]  side_b;
    logic [HYP_W-1:0] hyp;
    logic [ANG_W-1:0] angle_a;
    logic [ANG_W-1:0] angle_b;
    logic             degen;
  } triangle_t;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic [IN_W-1:0]  in_side_a      = '0;
  logic [IN_W-1:0]  in_side_b      = '0;
  logic             out_stall      = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [HYP_W-1:0] out_hypotenuse;
  logic [ANG_W-1:0] out_angle_a;
  logic [ANG_W-1:0] out_angle_b;
  logic             out_degenerate;

  triangle_t   expected_triangles[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_cycle    = 0;
  stall_mode_e stall_mode     = STALL_NONE;

  longint arctan_steps [CORDIC_STAGES] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001
  };

  right_triangle_hypotenuse_angles dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_side_a      (in_side_a),
    .in_side_b      (in_side_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hypotenuse (out_hypotenuse),
    .out_angle_a    (out_angle_a),
    .out_angle_b    (out_angle_b),
    .out_degenerate (out_degenerate)
  );

  always #2 clk = ~clk;

  function automatic logic [ANG_W-1:0] q30_to_angle(input longint q30);
    longint unsigned rounded;
    rounded = (longint'(q30) + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
    return rounded[ANG_W-1:0];
  endfunction

  function automatic triangle_t solve_triangle(input logic [IN_W-1:0] a,
                                               input logic [IN_W-1:0] b);
    triangle_t       t;
    longint unsigned sum_sq;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    longint          x;
    longint          y;
    longint          z;
    longint          x_next;
    t = '0;
    t.side_a = a;
    t.side_b = b;
    if (a == 0 && b == 0) begin
      t.degen = 1'b1;
      return t;
    end
    sum_sq = longint'(a) * longint'(a) + longint'(b) * longint'(b);
    rem = 0;
    root = 0;
    for (int k = 16; k >= 0; k--) begin
      rem = (rem << 2) | ((sum_sq >> (2 * k)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    if (rem > root) begin
      root = root + 1;
    end
    t.hyp = root[HYP_W-1:0];
    if (a == 0) begin
      z = 0;
    end else if (b == 0) begin
      z = longint'(HALF_PI_Q30);
    end else begin
      x = longint'(b) << SIDE_SCALE;
      y = longint'(a) << SIDE_SCALE;
      z = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (y >= 0) begin
          x_next = x + (y >>> i);
          y = y - (x >>> i);
          z = z + arctan_steps[i];
        end else begin
          x_next = x - (y >>> i);
          y = y + (x >>> i);
          z = z - arctan_steps[i];
        end
        x = x_next;
      end
      if (z < 0) begin
        z = 0;
      end
      if (z > longint'(HALF_PI_Q30)) begin
        z = longint'(HALF_PI_Q30);
      end
    end
    t.angle_a = q30_to_angle(z);
    t.angle_b = q30_to_angle(longint'(HALF_PI_Q30) - z);
    return t;
  endfunction

  task automatic report_mismatch(input string what, input triangle_t t,
                                 input longint unsigned expected_value,
                                 input longint unsigned got_value);
    $display("mismatch %s for legs %0d,%0d: expected %0d, got %0d", what,
             t.side_a, t.side_b, expected_value, got_value);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    triangle_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_triangles.size() == 0) begin
        t = '0;
        report_mismatch("unexpected transaction", t, 0, out_hypotenuse);
      end else begin
        t = expected_triangles.pop_front();
        if (out_hypotenuse !== t.hyp) begin
          report_mismatch("hypotenuse", t, t.hyp, out_hypotenuse);
        end
        if (out_angle_a !== t.angle_a) begin
          report_mismatch("angle_a", t, t.angle_a, out_angle_a);
        end
        if (out_angle_b !== t.angle_b) begin
          report_mismatch("angle_b", t, t.angle_b, out_angle_b);
        end
        if (out_degenerate !== t.degen) begin
          report_mismatch("degenerate", t, t.degen, out_degenerate);
        end
      end
    end
  end

  always @(posedge clk) begin
    stall_cycle++;
    if (stall_cycle % 256 == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= ((stall_cycle % 8) < 3);
      default:        out_stall <= 1'b0;
    endcase
  end

  task automatic send_legs(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
    in_valid  <= 1'b1;
    in_side_a <= a;
    in_side_b <= b;
    do @(posedge clk); while (in_stall);
    expected_triangles.push_back(solve_triangle(a, b));
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      in_valid  <= 1'b0;
      in_side_a <= IN_W'($urandom);
      in_side_b <= IN_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic pace_burst();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 8));
      end
    end
    burst_left--;
  endtask

  task automatic wait_for_results();
    in_valid  <= 1'b0;
    in_side_a <= IN_W'($urandom);
    in_side_b <= IN_W'($urandom);
    while (expected_triangles.size() != 0) @(posedge clk);
  endtask

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    logic [IN_W-1:0] legs [18][2] = '{
      '{16'd0, 16'd0}, '{16'd0, 16'd1}, '{16'd1, 16'd0},
      '{16'd0, 16'hFFFF}, '{16'hFFFF, 16'd0}, '{16'hFFFF, 16'hFFFF},
      '{16'd1, 16'd1}, '{16'd1, 16'hFFFF}, '{16'hFFFF, 16'd1},
      '{16'd3, 16'd4}, '{16'd5, 16'd12}, '{16'h8000, 16'h8000},
      '{16'hAAAA, 16'h5555}, '{16'h5555, 16'hAAAA}, '{16'd1, 16'd2},
      '{16'd2, 16'd1}, '{16'hFFFE, 16'hFFFF}, '{16'd255, 16'd256}
    };
    foreach (legs[i]) begin
      send_legs(legs[i][0], legs[i][1]);
      idle_cycles($urandom_range(0, 2));
    end
  endtask

  task automatic test_random_legs();
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      a = IN_W'($urandom);
      b = IN_W'($urandom);
      case ($urandom_range(0, 9))
        0: a = '0;
        1: b = '0;
        2: begin
          a = IN_W'($urandom_range(0, 15));
          b = IN_W'($urandom_range(0, 15));
        end
        3: b = a + IN_W'($urandom_range(0, 3)) - IN_W'(1);
        4: a = IN_W'($urandom_range(1, 7));
        5: b = IN_W'($urandom_range(1, 7));
        default: ;
      endcase
      pace_burst();
      send_legs(a, b);
    end
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 40; n++) begin
      send_legs(IN_W'($urandom), IN_W'($urandom));
      if (n == 19) begin
        wait_for_results();
      end
    end
  endtask

  initial begin
    apply_reset();
    test_directed_extremes();
    test_random_legs();
    test_drain_pause();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_triangles.size() == 0) begin
      $display("right_triangle_hypotenuse_angles regression: pass");
    end else begin
      $display("right_triangle_hypotenuse_angles regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("right_triangle_hypotenuse_angles regression: fail");
    $finish;
  end

endmodule
